// ----- src/ultrasonic_echo_ranger_assert.svh -----
// Assertion macros for the ultrasonic echo ranger.
// Depends on nothing; included by ultrasonic_echo_ranger, which checks itself.
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH

// Check a consequence in the same cycle as its antecedent.
`define UER_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the cycle after its antecedent.
`define UER_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/uer_pkg.sv -----
// Shared types and constants for the ultrasonic echo ranger.
// Depends on nothing; imported by ultrasonic_echo_ranger.
package uer_pkg;

   // Field widths
   localparam int TIMEOUT_W   = 14;
   localparam int HOLDOFF_W   = 10;
   localparam int TRIGGER_W   = 8;
   localparam int ECHO_US_W   = 24;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 2;

   // Parameter defaults
   localparam int COUNT_WIDTH_DEF  = 24;
   localparam int TICKS_PER_MS_DEF = 1000;

   // Register reset values
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = TIMEOUT_W'(1000);
   localparam logic [HOLDOFF_W-1:0] HOLDOFF_RST = HOLDOFF_W'(60);
   localparam logic [TRIGGER_W-1:0] TRIGGER_RST = TRIGGER_W'(10);

   localparam logic [ECHO_US_W-1:0] ECHO_US_MAX = '1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_HOLDOFF = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_TRIGGER = CSR_INDEX_W'(2);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HOLDOFF,
      PH_TRIGGER,
      PH_ARMED
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK,
      ST_TIMEOUT,
      ST_BUSY
   } status_type;

   typedef struct packed {
      logic                 trigger_level;
      logic                 busy_res;
      logic                 report_valid;
      status_type           status;
      logic [ECHO_US_W-1:0] echo_us;
   } result_type;

endpackage

// ----- src/ultrasonic_echo_ranger.sv -----
// Ultrasonic echo ranger: trigger sequencing and echo pulse timing, one tick per beat.
// Depends on uer_pkg and ultrasonic_echo_ranger_assert.svh.
// The result of an accepted beat is registered into the output head, or the skid entry while the head stalls.
// Throughput: one beat per cycle while req_stall is low; a two-entry output buffer keeps req_stall registered.
// Reset (synchronous, active high): idle phase, counters cleared, registers to defaults.
// Limit compares run on tick counts precomputed at each register write.
`include "ultrasonic_echo_ranger_assert.svh"

module ultrasonic_echo_ranger
   import uer_pkg::*;
#(
   parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF,
   parameter int TICKS_PER_MS = TICKS_PER_MS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // input beats
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_start_req,
   input  logic                   req_echo_level,
   // result beats
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_trigger_level,
   output logic                   rsp_busy_res,
   output logic                   rsp_report_valid,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [ECHO_US_W-1:0]   rsp_echo_us,
   // register writes
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [TIMEOUT_W-1:0]   csr_wdata
);

   // Width of the ms-to-tick product and of the saturating echo compare.
   localparam int TPM_W  = $clog2(TICKS_PER_MS + 1);
   localparam int PROD_W = TIMEOUT_W + TPM_W;
   localparam int MW     = (PROD_W > COUNT_WIDTH) ? PROD_W : COUNT_WIDTH;
   localparam int OW     = (COUNT_WIDTH > ECHO_US_W) ? COUNT_WIDTH : ECHO_US_W;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

   // Convert milliseconds to ticks, clamped to the counter range.
   function automatic logic [COUNT_WIDTH-1:0] ms_to_ticks(input logic [TIMEOUT_W-1:0] ms);
      logic [MW-1:0] prod;
      prod = MW'(ms) * MW'(TICKS_PER_MS);
      if (prod > MW'(CNT_MAX)) begin
         prod = MW'(CNT_MAX);
      end
      return prod[COUNT_WIDTH-1:0];
   endfunction

   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
      return (v == CNT_MAX) ? v : v + COUNT_WIDTH'(1);
   endfunction

   // ------------------------------------------------------------------
   // Configuration: hold limits as tick counts so the beat path only compares.
   // ------------------------------------------------------------------
   logic [COUNT_WIDTH-1:0] timeout_lim_ff;
   logic [COUNT_WIDTH-1:0] holdoff_lim_ff;
   logic [TRIGGER_W-1:0]   trigger_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_lim_ff <= ms_to_ticks(TIMEOUT_RST);
         holdoff_lim_ff <= ms_to_ticks(TIMEOUT_W'(HOLDOFF_RST));
         trigger_ff     <= TRIGGER_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TIMEOUT: timeout_lim_ff <= ms_to_ticks(csr_wdata);
            CSR_HOLDOFF: holdoff_lim_ff <= ms_to_ticks(TIMEOUT_W'(csr_wdata[HOLDOFF_W-1:0]));
            CSR_TRIGGER: trigger_ff     <= csr_wdata[TRIGGER_W-1:0];
            default: ; // drop writes to unknown indexes
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Measurement state
   // ------------------------------------------------------------------
   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] phase_count_ff, phase_count_in;
   logic                   echo_prev_ff;
   logic                   rise_seen_ff, rise_seen_in;
   logic [COUNT_WIDTH-1:0] width_count_ff, width_count_in;

   logic       busy_before;
   logic       rising;
   logic       falling;
   logic       used;
   logic [OW-1:0] width_wide;
   result_type res_in;

   // Output buffer: head drives the result port, skid catches a beat while head stalls.
   result_type head_ff, head_in;
   result_type skid_ff, skid_in;
   logic       head_vld_ff, head_vld_in;
   logic       skid_vld_ff, skid_vld_in;
   logic       push;
   logic       pop;

   assign req_stall = skid_vld_ff;
   assign push      = req_valid && !req_stall;
   assign pop       = head_vld_ff && !rsp_stall;

   // One tick of the sequencer: holdoff, trigger, then armed echo timing.
   always_comb begin
      busy_before    = (phase_ff != PH_IDLE);
      rising         = !echo_prev_ff && req_echo_level;
      falling        = echo_prev_ff && !req_echo_level;
      used           = 1'b0;
      phase_in       = phase_ff;
      phase_count_in = phase_count_ff;
      rise_seen_in   = rise_seen_ff;
      width_count_in = width_count_ff;
      width_wide     = OW'(width_count_ff);
      res_in         = '0;
      res_in.status  = ST_OK;

      // Start from idle: this tick is the first holdoff tick.
      if (!busy_before && req_start_req) begin
         phase_in       = PH_HOLDOFF;
         phase_count_in = '0;
      end

      if (phase_in == PH_HOLDOFF) begin
         if (holdoff_lim_ff == '0) begin
            // no holdoff: fall straight into the trigger on this tick
            phase_in       = PH_TRIGGER;
            phase_count_in = '0;
         end else begin
            used           = 1'b1;
            phase_count_in = sat_inc(phase_count_in);
            if (phase_count_in >= holdoff_lim_ff) begin
               phase_in       = PH_TRIGGER;
               phase_count_in = '0;
            end
         end
      end

      if (!used && phase_in == PH_TRIGGER) begin
         res_in.trigger_level = 1'b1;
         phase_count_in       = sat_inc(phase_count_in);
         // a zero width still drives one tick
         if (phase_count_in >= COUNT_WIDTH'(trigger_ff)) begin
            phase_in       = PH_ARMED;
            phase_count_in = '0;
            rise_seen_in   = 1'b0;
            width_count_in = '0;
         end
      end else if (!used && phase_in == PH_ARMED) begin
         phase_count_in = sat_inc(phase_count_in);
         // a later rising edge restarts the width
         if (rising) begin
            rise_seen_in   = 1'b1;
            width_count_in = '0;
         end else if (rise_seen_in) begin
            width_count_in = sat_inc(width_count_in);
         end
         width_wide = OW'(width_count_in);
         // count a falling edge only once a rising edge was seen
         if (falling && rise_seen_in) begin
            res_in.report_valid = 1'b1;
            res_in.status       = ST_OK;
            res_in.echo_us      = (width_wide > OW'(ECHO_US_MAX)) ? ECHO_US_MAX
                                                                : width_wide[ECHO_US_W-1:0];
            phase_in            = PH_IDLE;
            phase_count_in      = '0;
         end else if (phase_count_in >= timeout_lim_ff) begin
            res_in.report_valid = 1'b1;
            res_in.status       = ST_TIMEOUT;
            phase_in            = PH_IDLE;
            phase_count_in      = '0;
         end
      end

      // Reject a start while busy, unless the measurement ends on this tick.
      if (busy_before && req_start_req && !res_in.report_valid) begin
         res_in.report_valid = 1'b1;
         res_in.status       = ST_BUSY;
      end

      res_in.busy_res = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         phase_count_ff <= '0;
         echo_prev_ff   <= 1'b0;
         rise_seen_ff   <= 1'b0;
         width_count_ff <= '0;
      end else if (push) begin
         phase_ff       <= phase_in;
         phase_count_ff <= phase_count_in;
         echo_prev_ff   <= req_echo_level;
         rise_seen_ff   <= rise_seen_in;
         width_count_ff <= width_count_in;
      end
   end

   // ------------------------------------------------------------------
   // Output buffer control
   // ------------------------------------------------------------------
   always_comb begin
      head_in     = head_ff;
      skid_in     = skid_ff;
      head_vld_in = head_vld_ff;
      skid_vld_in = skid_vld_ff;
      if (pop) begin
         if (skid_vld_ff) begin
            // advance the skid beat; input is stalled so no push here
            head_in     = skid_ff;
            skid_vld_in = 1'b0;
         end else begin
            head_in     = res_in;
            head_vld_in = push;
         end
      end else if (push) begin
         if (!head_vld_ff) begin
            head_in     = res_in;
            head_vld_in = 1'b1;
         end else begin
            skid_in     = res_in;
            skid_vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         head_vld_ff <= head_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = head_vld_ff;
   assign rsp_trigger_level = head_ff.trigger_level;
   assign rsp_busy_res      = head_ff.busy_res;
   assign rsp_report_valid  = head_ff.report_valid;
   assign rsp_status        = head_ff.status;
   assign rsp_echo_us       = head_ff.echo_us;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `UER_ASSERT_NOW(a_skid_behind_head, clock, reset, skid_vld_ff, head_vld_ff,
      "skid entry valid without a head entry")

   `UER_ASSERT_NOW(a_busy_start_reported, clock, reset,
      push && req_start_req && phase_ff != PH_IDLE, res_in.report_valid,
      "start while busy produced no report")

   `UER_ASSERT_NEXT(a_end_goes_idle, clock, reset,
      push && res_in.report_valid && res_in.status != ST_BUSY, phase_ff == PH_IDLE,
      "measurement ended but phase is not idle")

   `UER_ASSERT_NEXT(a_idle_start_holds, clock, reset,
      push && req_start_req && phase_ff == PH_IDLE, phase_ff != PH_IDLE,
      "start from idle did not begin a measurement")

endmodule
